FILE: hw/rtl/windowed_power_level_meter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed power level meter.
// The enclosing scope must provide clk and the active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_POWER_LEVEL_METER_DEFINES_SVH
`define WINDOWED_POWER_LEVEL_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPL_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("windowed_power_level_meter: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("windowed_power_level_meter: check failed");

`endif

FILE: hw/rtl/wpl_pkg.sv
// ----------------------------------------------------------------------------
// wpl_pkg: shared types and constants
// Widths, window scaling constants and the bar graph thresholds.
// ----------------------------------------------------------------------------
package wpl_pkg;

    localparam int WINDOW   = 1000;
    localparam int SAMPLE_W = 12;
    localparam int SQ_W     = 2 * SAMPLE_W;
    localparam int SUM_W    = 24;
    localparam int BAR_W    = 8;

    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int MAX_ENTRY  = (SAMPLE_MAX * SAMPLE_MAX) / WINDOW;
    localparam int ENTRY_W    = $clog2(MAX_ENTRY + 1);
    localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam logic [IDX_W-1:0] WINDOW_LAST = IDX_W'(WINDOW - 1);

    // Division by the window length as a multiply by a rounded-up reciprocal.
    // With the shift at SQ_W plus the bit length of WINDOW the quotient is
    // exact for every square that fits SQ_W bits.
    localparam int RECIP_SHIFT = SQ_W + $clog2(WINDOW);
    localparam int RECIP_W     = SQ_W + 1;
    localparam int PROD_W      = SQ_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW));

    localparam logic [SUM_W-1:0] BAR_LIMITS [BAR_W] = '{
        SUM_W'(5), SUM_W'(25), SUM_W'(125), SUM_W'(625),
        SUM_W'(3125), SUM_W'(15625), SUM_W'(78125), SUM_W'(390625)
    };

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [SUM_W-1:0] power_sum;
        logic [BAR_W-1:0] bar_leds;
    } result_t;

    typedef struct packed {
        logic stage_a;
        logic stage_b;
    } pipe_status_t;

    function automatic logic [BAR_W-1:0] bar_code(input logic [SUM_W-1:0] level);
        logic [BAR_W-1:0] bars;
        bars = '0;
        for (int k = 0; k < BAR_W; k++)
        begin
            bars[k] = (level > BAR_LIMITS[k]);
        end
        return bars;
    endfunction

endpackage

FILE: hw/rtl/wpl_ram.sv
// ----------------------------------------------------------------------------
// wpl_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wpl_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] store_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= store_mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/wpl_out_fifo.sv
// ----------------------------------------------------------------------------
// wpl_out_fifo: result queue
// Small register queue that holds finished results until they are taken.
// ----------------------------------------------------------------------------
module wpl_out_fifo
    import wpl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  result_t               push_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output result_t               pop_data,
    output logic [FIFO_CNT_W-1:0] count
);

    result_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] head_reg, head_next;
    logic [FIFO_PTR_W-1:0] tail_reg, tail_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign pop_data  = slot_reg[head_reg];
    assign count     = count_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        head_next  = pop  ? head_reg + FIFO_PTR_W'(1) : head_reg;
        tail_next  = push ? tail_reg + FIFO_PTR_W'(1) : tail_reg;
        count_next = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/wpl_core.sv
// ----------------------------------------------------------------------------
// wpl_core: window ring and running sum
// Squares and scales each sample, reads the oldest entry from the ring RAM,
// forwards entries still in flight, and updates the running sum.
// ----------------------------------------------------------------------------
module wpl_core
    import wpl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [SAMPLE_W-1:0] sample,
    output pipe_status_t        status,
    output logic                res_vld,
    output result_t             res
);

    // Ring position and first-lap tracking.
    logic [IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic               lap_done_reg;

    // Stage A: square registered, ring read in flight.
    logic               vld_a_reg;
    logic [SQ_W-1:0]    sq_a_reg;
    logic [IDX_W-1:0]   idx_a_reg;
    logic               fresh_a_reg;

    // Stage B: scaled entry and the entry it replaces.
    logic               vld_b_reg;
    logic [ENTRY_W-1:0] entry_b_reg;
    logic [ENTRY_W-1:0] old_b_reg;
    logic [IDX_W-1:0]   idx_b_reg;

    // Most recent ring write, for forwarding over the RAM read latency.
    logic               lw_vld_reg;
    logic [IDX_W-1:0]   lw_idx_reg;
    logic [ENTRY_W-1:0] lw_data_reg;

    logic [SUM_W-1:0]   sum_reg, sum_next;

    logic [ENTRY_W-1:0] rd_data;
    logic [PROD_W-1:0]  prod_a;
    logic [ENTRY_W-1:0] entry_a;
    logic [ENTRY_W-1:0] old_a;

    wpl_ram #(
        .DEPTH (WINDOW),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (vld_b_reg),
        .wr_addr (idx_b_reg),
        .wr_data (entry_b_reg),
        .rd_en   (in_fire),
        .rd_addr (wr_ptr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == WINDOW_LAST) ? '0 : wr_ptr_reg + IDX_W'(1);
        prod_a      = PROD_W'(sq_a_reg) * PROD_W'(RECIP);
        entry_a     = ENTRY_W'(prod_a >> RECIP_SHIFT);

        // The newest write to the same entry wins; an entry never written
        // during the first lap reads as zero.
        if (vld_b_reg && (idx_b_reg == idx_a_reg))
        begin
            old_a = entry_b_reg;
        end
        else if (lw_vld_reg && (lw_idx_reg == idx_a_reg))
        begin
            old_a = lw_data_reg;
        end
        else if (fresh_a_reg)
        begin
            old_a = '0;
        end
        else
        begin
            old_a = rd_data;
        end

        sum_next = sum_reg - SUM_W'(old_b_reg) + SUM_W'(entry_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            lap_done_reg <= 1'b0;
            vld_a_reg    <= 1'b0;
            vld_b_reg    <= 1'b0;
            lw_vld_reg   <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            vld_a_reg <= in_fire;
            vld_b_reg <= vld_a_reg;
            if (in_fire)
            begin
                wr_ptr_reg <= wr_ptr_next;
                if (wr_ptr_reg == WINDOW_LAST)
                begin
                    lap_done_reg <= 1'b1;
                end
            end
            if (vld_b_reg)
            begin
                lw_vld_reg <= 1'b1;
                sum_reg    <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sq_a_reg    <= SQ_W'(sample) * SQ_W'(sample);
            idx_a_reg   <= wr_ptr_reg;
            fresh_a_reg <= !lap_done_reg;
        end
        if (vld_a_reg)
        begin
            entry_b_reg <= entry_a;
            old_b_reg   <= old_a;
            idx_b_reg   <= idx_a_reg;
        end
        if (vld_b_reg)
        begin
            lw_idx_reg  <= idx_b_reg;
            lw_data_reg <= entry_b_reg;
        end
    end

    assign status.stage_a = vld_a_reg;
    assign status.stage_b = vld_b_reg;
    assign res_vld        = vld_b_reg;
    assign res.power_sum  = sum_next;
    assign res.bar_leds   = bar_code(sum_next);

endmodule

FILE: hw/rtl/windowed_power_level_meter.sv
// ----------------------------------------------------------------------------
// windowed_power_level_meter: moving-window mean-square level meter
// One sample beat per cycle while the result queue has room; results are queued.
// The ring RAM read/modify/write path with forwarding sets the pace.
// Reset clears the sum and index; no RAM clear pass, the first lap reads zero.
// ----------------------------------------------------------------------------
module windowed_power_level_meter
    import wpl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SUM_W-1:0]    power_sum,
    output logic [BAR_W-1:0]    bar_leds
);

    // Each accepted sample walks a fixed three-stage pipe that never stalls:
    // the square is registered together with a read of the oldest ring entry,
    // the square is scaled by the window length while the old entry is
    // resolved against writes still in flight, and the running sum is then
    // updated while the new entry is written back in place of the old one.
    //
    // Because the pipe cannot stall, back-pressure is handled by a small
    // result queue. A new sample beat is taken only when the queue has room
    // for every item already in the pipe plus the new one, so in_ready comes
    // from registers alone and never depends on out_ready in the same cycle.

    pipe_status_t          status;
    logic                  in_fire;
    logic                  res_vld;
    result_t               res;
    result_t               head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W-1:0] occupancy;

    // Items in the queue plus items still in the pipe.
    assign occupancy = fifo_count + FIFO_CNT_W'(status.stage_a) + FIFO_CNT_W'(status.stage_b);
    assign in_ready  = (occupancy < FIFO_CNT_W'(FIFO_DEPTH));
    assign in_fire   = in_valid && in_ready;

    wpl_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .sample  (sample),
        .status  (status),
        .res_vld (res_vld),
        .res     (res)
    );

    // The queue decouples the result beat from the sample beat.
    wpl_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_vld),
        .push_data (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pop_data  (head),
        .count     (fifo_count)
    );

    assign power_sum = head.power_sum;
    assign bar_leds  = head.bar_leds;

endmodule

FILE: hw/rtl/wpl_checker.sv
// ----------------------------------------------------------------------------
// wpl_checker: port-level checks
// Watches the top-level ports of the meter and is bound to it.
// ----------------------------------------------------------------------------
`include "windowed_power_level_meter_defines.svh"

module wpl_checker
    import wpl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [SAMPLE_W-1:0] sample,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SUM_W-1:0]    power_sum,
    input logic [BAR_W-1:0]    bar_leds
);

    // A result beat that is held back keeps its value.
    `WPL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(power_sum) && $stable(bar_leds))

    // The bar graph is a thermometer code.
    `WPL_ASSERT_IMPLY(a_bar_thermo, out_valid, ((bar_leds >> 1) & ~bar_leds) == '0)

    // The lowest and highest bars agree with the reported level.
    `WPL_ASSERT_IMPLY(a_bar_ends, out_valid, (bar_leds[0] == (power_sum > BAR_LIMITS[0])) && (bar_leds[BAR_W-1] == (power_sum > BAR_LIMITS[BAR_W-1])))

    // An empty output only fills from a sample taken earlier, after it has passed stages A and B into the queue.
    `WPL_ASSERT_IMPLY(a_out_origin, $rose(out_valid), $past(in_valid && in_ready, 3))

endmodule

bind windowed_power_level_meter wpl_checker u_wpl_checker (.*);

FILE: tb/sv/windowed_power_level_meter_test.sv
// ----------------------------------------------------------------------------
// Windowed power level meter regression
// Drives converter samples into the meter through the sample channel and checks
// every reading beat (running mean-square sum and thermometer bar graph)
// against a cycle-free model of the ring and the sum. It runs a directed
// opening, random bursts of varied amplitude, a gap-free run of rail
// samples and a short random tail. Both channels idle at random, the
// reading side holds off long enough to back the meter up, and the sample
// side pauses at times until every reading has come back.
// ----------------------------------------------------------------------------
module windowed_power_level_meter_test
    import wpl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 12;
    localparam int          RANDOM_ITEMS   = 455;
    localparam int          RAIL_ITEMS     = 100;
    localparam int          MAX_GAP        = 8;
    localparam int          LONG_HOLD      = 80;
    localparam int          FIRST_HOLD_AT  = 40;
    localparam int          SECOND_HOLD_AT = 500;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int          PRINT_LIMIT    = 100;

    // Amplitude profile of one random burst of samples.
    typedef enum int unsigned
    {
        AMP_FULL,
        AMP_QUIET,
        AMP_MID,
        AMP_HELD,
        AMP_RAIL
    } amplitude_e;

    // One sample waiting to be offered, with the idle cycles that come before
    // it and whether the sender first waits for every outstanding reading.
    typedef struct
    {
        logic [SAMPLE_W-1:0] value;
        int unsigned         gap;
        bit                  drain;
    } sample_beat_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [SAMPLE_W-1:0] sample    = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [SUM_W-1:0]    power_sum;
    logic [BAR_W-1:0]    bar_leds;

    // Samples not yet offered, and readings predicted but not yet seen.
    sample_beat_t pending_beats[$];
    result_t      meter_readings_q[$];

    // Model of the meter: the ring of scaled squares, its write slot and sum.
    logic [ENTRY_W-1:0] square_ring [WINDOW];
    int unsigned        ring_slot;
    logic [SUM_W-1:0]   window_level;

    int unsigned mismatch_count = 0;
    int unsigned readings_seen  = 0;
    int unsigned stall_cycles   = 0;

    // Driver and monitor working variables.
    int unsigned gap_left;
    bit          gap_armed;
    logic        drive_valid;
    int unsigned ready_wait;
    int unsigned hold_left;
    logic        drive_ready;
    result_t     predicted;

    windowed_power_level_meter DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .power_sum (power_sum),
        .bar_leds  (bar_leds)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Adds one sample to the window model and queues the reading it yields.
    // The oldest square leaves the sum, the new one takes its slot and joins
    // the sum, and the slot advances with wrap at the window length.
    task automatic advance_meter(input logic [SAMPLE_W-1:0] value);
        int unsigned      square;
        int unsigned      threshold;
        result_t          reading;
        square = int'(value) * int'(value);
        window_level = window_level - SUM_W'(square_ring[ring_slot]);
        square_ring[ring_slot] = ENTRY_W'(square / WINDOW);
        window_level = window_level + SUM_W'(square_ring[ring_slot]);
        ring_slot = (ring_slot + 1 == WINDOW) ? 0 : ring_slot + 1;
        // Bar k lights when the level is strictly above 5 times 5 to the k.
        threshold = 5;
        reading.power_sum = window_level;
        for (int k = 0; k < BAR_W; k++)
        begin
            reading.bar_leds[k] = (int'(window_level) > threshold);
            threshold = threshold * 5;
        end
        meter_readings_q.push_back(reading);
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] value, input int unsigned gap,
                                input bit drain);
        sample_beat_t beat;
        beat.value = value;
        beat.gap   = gap;
        beat.drain = drain;
        pending_beats.push_back(beat);
    endtask

    // Sample driver. A beat that was accepted at this edge goes into the
    // model; then, if the channel is free, the next pending sample is offered
    // once its idle gap has run out. A sample marked to drain is held back
    // until no reading is outstanding. While valid is high and the meter is
    // not ready, nothing here touches valid or the sample.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            sample    <= '0;
            gap_left  = 0;
            gap_armed = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_meter(sample);
            end
            if (!in_valid || in_ready)
            begin
                drive_valid = 1'b0;
                if (pending_beats.size() != 0)
                begin
                    if (!gap_armed)
                    begin
                        gap_left  = pending_beats[0].gap;
                        gap_armed = 1'b1;
                    end
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    else if (!(pending_beats[0].drain && meter_readings_q.size() != 0))
                    begin
                        sample      <= pending_beats[0].value;
                        drive_valid = 1'b1;
                        void'(pending_beats.pop_front());
                        gap_armed   = 1'b0;
                    end
                end
                in_valid <= drive_valid;
            end
        end
    end

    // Reading monitor. Every accepted reading beat is compared field by field
    // with the oldest prediction. Ready then drops for a drawn number of
    // cycles; in every third stretch of 64 readings it drops only for a long
    // hold. At two points ready stays low for a long hold so that the meter
    // backs up and stops taking samples.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_wait = 0;
            hold_left  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                readings_seen++;
                if (meter_readings_q.size() == 0)
                begin
                    report_mismatch($sformatf("reading sum %0d bars %b with no sample pending",
                                              power_sum, bar_leds));
                end
                else
                begin
                    predicted = meter_readings_q.pop_front();
                    if (power_sum !== predicted.power_sum)
                    begin
                        report_mismatch($sformatf("reading %0d power_sum %0d, predicted %0d",
                                                  readings_seen, power_sum,
                                                  predicted.power_sum));
                    end
                    if (bar_leds !== predicted.bar_leds)
                    begin
                        report_mismatch($sformatf("reading %0d bar_leds %b, predicted %b",
                                                  readings_seen, bar_leds,
                                                  predicted.bar_leds));
                    end
                end
                ready_wait = ((readings_seen / 64) % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
                if (readings_seen == FIRST_HOLD_AT || readings_seen == SECOND_HOLD_AT)
                begin
                    hold_left = LONG_HOLD;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                drive_ready = 1'b0;
            end
            else if (ready_wait > 0)
            begin
                ready_wait--;
                drive_ready = 1'b0;
            end
            else
            begin
                drive_ready = 1'b1;
            end
            out_ready <= drive_ready;
        end
    end

    // Watchdog: ends the run when neither channel has moved a beat for too
    // long. The longest correct silence is the long hold plus a few gaps.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int unsigned         made;
        int unsigned         run_len;
        amplitude_e          profile;
        bit                  steady;
        logic [SAMPLE_W-1:0] held;
        logic [SAMPLE_W-1:0] value;

        // The model starts where reset leaves the meter: empty ring, zero sum.
        for (int i = 0; i < WINDOW; i++)
        begin
            square_ring[i] = '0;
        end
        ring_slot    = 0;
        window_level = '0;

        // Directed opening. The first steps walk the sum up to exactly the
        // lowest bar threshold and then one past it, so the strict compare is
        // seen at its edge. Then come the rails and alternating bit patterns.
        queue_sample(12'd0, 0, 1'b0);
        queue_sample(12'd70, 0, 1'b0);      // square 4900 scales to 4
        queue_sample(12'd32, 1, 1'b0);      // adds 1: sum sits on the threshold
        queue_sample(12'd32, 0, 1'b0);      // one more: the first bar lights
        queue_sample(12'd1, 2, 1'b0);       // scales to zero
        queue_sample(12'd158, 0, 1'b0);     // adds 24: the second bar lights
        queue_sample(12'd31, 0, 1'b0);
        queue_sample(12'd4095, 3, 1'b0);
        queue_sample(12'd0, 0, 1'b0);
        queue_sample(12'd2730, 0, 1'b0);
        queue_sample(12'd1365, 1, 1'b0);
        queue_sample(12'd2048, 0, 1'b0);
        queue_sample(12'd2047, 0, 1'b0);
        queue_sample(12'd4094, 4, 1'b0);
        queue_sample(12'd4095, 0, 1'b0);

        // Random bursts, each of one amplitude profile and one idling style.
        // The first burst waits until the directed readings are all back.
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            run_len = $urandom_range(1, 40);
            profile = amplitude_e'($urandom_range(0, 4));
            steady  = ($urandom_range(0, 3) == 0);
            held    = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            for (int i = 0; i < run_len; i++)
            begin
                case (profile)
                    AMP_FULL:  value = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                    AMP_QUIET: value = SAMPLE_W'($urandom_range(0, 90));
                    AMP_MID:   value = SAMPLE_W'($urandom_range(0, 1000));
                    AMP_HELD:  value = held;
                    default:   value = ($urandom_range(0, 1) == 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
                endcase
                queue_sample(value, steady ? 0 : $urandom_range(0, MAX_GAP),
                             (i == 0) && (made == 0 || $urandom_range(0, 7) == 0));
                made++;
            end
        end

        // A gap-free run of rail samples after a full drain. The second long
        // hold of the reading side falls inside this stretch, so the meter
        // backs up here while the sender keeps offering.
        for (int i = 0; i < RAIL_ITEMS; i++)
        begin
            queue_sample(SAMPLE_W'(SAMPLE_MAX), 0, i == 0);
        end

        // A short random tail after the rail run.
        for (int i = 0; i < 30; i++)
        begin
            queue_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), $urandom_range(0, MAX_GAP),
                         1'b0);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last sample to be taken and its reading to return,
        // then give the pipeline time to show any stray extra beat.
        while (pending_beats.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (meter_readings_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/wpl_pkg.sv
hw/rtl/wpl_ram.sv
hw/rtl/wpl_out_fifo.sv
hw/rtl/wpl_core.sv
hw/rtl/windowed_power_level_meter.sv
hw/rtl/wpl_checker.sv
tb/sv/windowed_power_level_meter_test.sv
